// File: hw/rtl/byte_level_token_decoder_assert.svh
// ----------------------------------------------------------------------------
// Byte-level token decoder assertion macros
// Shorthand for clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_LEVEL_TOKEN_DECODER_ASSERT_SVH
`define BYTE_LEVEL_TOKEN_DECODER_ASSERT_SVH

// Assertion that is switched off while reset is high
`define BLTD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset
`define BLTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bltd_pkg.sv
// ----------------------------------------------------------------------------
// bltd_pkg
// Types, constants and the code point mapping for the byte-level decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bltd_pkg;

   localparam int unsigned CP_WIDTH    = 21;
   localparam int unsigned COUNT_WIDTH = 16;

   localparam logic [COUNT_WIDTH-1:0] OUTPUT_LIMIT_RESET = 16'hFFFF;
   localparam logic [CP_WIDTH-1:0]    REPLACEMENT_CHAR   = 21'h00FFFD;

   // Lead byte classes: mask and expected pattern
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'h3F;

   // Continuation bytes still owed to the open character
   localparam logic [1:0] OWE_NONE  = 2'd0;
   localparam logic [1:0] OWE_ONE   = 2'd1;
   localparam logic [1:0] OWE_TWO   = 2'd2;
   localparam logic [1:0] OWE_THREE = 2'd3;

   localparam logic [CP_WIDTH-1:0] REMAP_BASE = 21'd256;
   localparam logic [CP_WIDTH-1:0] REMAP_END  = 21'd324;
   localparam logic [6:0]          REMAP_LOW_LAST = 7'd32;
   localparam logic [6:0]          REMAP_MID_LAST = 7'd66;
   localparam logic [7:0]          REMAP_MID_ADD  = 8'd94;
   localparam logic [7:0]          REMAP_SOFT_HYPHEN = 8'd173;

   typedef struct packed {
      logic       hit;
      logic [7:0] raw;
   } bltd_map_type;

   typedef struct packed {
      logic                   emit;
      logic [7:0]             out_byte;
      logic                   token_end;
      logic [COUNT_WIDTH-1:0] byte_count;
   } bltd_result_type;

   // Map a finished code point back to its raw byte
   function automatic bltd_map_type map_codepoint(input logic [CP_WIDTH-1:0] cp);
      bltd_map_type        res;
      logic [CP_WIDTH-1:0] off;
      logic [6:0]          n;
      res = '0;
      off = cp - REMAP_BASE;
      n   = off[6:0];
      if (cp < REMAP_BASE) begin
         res.hit = 1'b1;
         res.raw = cp[7:0];
      end else if (cp < REMAP_END) begin
         res.hit = 1'b1;
         if (n <= REMAP_LOW_LAST) begin
            res.raw = {1'b0, n};
         end else if (n <= REMAP_MID_LAST) begin
            res.raw = {1'b0, n} + REMAP_MID_ADD;
         end else begin
            res.raw = REMAP_SOFT_HYPHEN;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bltd_step.sv
// ----------------------------------------------------------------------------
// bltd_step
// Per-byte UTF-8 accumulate, code point remap and per-token byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module bltd_step
   import bltd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [7:0]             in_byte,
   input  wire logic                   last_byte,
   input  wire logic [COUNT_WIDTH-1:0] output_limit,
   output bltd_result_type             result
);

   logic [1:0]             remaining_ff, remaining_in;
   logic [CP_WIDTH-1:0]    accum_ff, accum_in;
   logic [COUNT_WIDTH-1:0] written_ff, written_in;

   logic                   done;
   logic [CP_WIDTH-1:0]    accum_step;
   logic [1:0]             remaining_step;
   bltd_map_type           mapped;
   logic                   emit;

   always_comb begin
      done           = 1'b0;
      accum_step     = accum_ff;
      remaining_step = remaining_ff;
      if (remaining_ff != OWE_NONE) begin
         // shift six payload bits in, continuation marker is not checked
         accum_step     = {accum_ff[CP_WIDTH-7:0], in_byte[5:0] & CONT_MASK[5:0]};
         remaining_step = remaining_ff - 2'd1;
         done           = (remaining_ff == OWE_ONE);
      end else if (!in_byte[7]) begin
         accum_step = {13'd0, in_byte};
         done       = 1'b1;
      end else if ((in_byte & LEAD2_MASK) == LEAD2_PAT) begin
         accum_step     = {16'd0, in_byte[4:0]};
         remaining_step = OWE_ONE;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_PAT) begin
         accum_step     = {17'd0, in_byte[3:0]};
         remaining_step = OWE_TWO;
      end else if ((in_byte & LEAD4_MASK) == LEAD4_PAT) begin
         accum_step     = {18'd0, in_byte[2:0]};
         remaining_step = OWE_THREE;
      end else begin
         accum_step = REPLACEMENT_CHAR;
         done       = 1'b1;
      end
      // finish a cut-short character with the bits gathered so far
      if (last_byte) begin
         done = 1'b1;
      end
   end

   assign mapped = map_codepoint(accum_step);
   assign emit   = done && mapped.hit && (written_ff < output_limit);

   always_comb begin
      remaining_in = remaining_step;
      accum_in     = accum_step;
      written_in   = written_ff;
      if (done) begin
         remaining_in = OWE_NONE;
         accum_in     = '0;
      end
      if (emit) begin
         written_in = written_ff + 16'd1;
      end
   end

   assign result.emit       = emit;
   assign result.out_byte   = emit ? mapped.raw : 8'd0;
   assign result.token_end  = last_byte;
   assign result.byte_count = written_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= OWE_NONE;
         accum_ff     <= '0;
         written_ff   <= '0;
      end else if (advance) begin
         if (last_byte) begin
            remaining_ff <= OWE_NONE;
            accum_ff     <= '0;
            written_ff   <= '0;
         end else begin
            remaining_ff <= remaining_in;
            accum_ff     <= accum_in;
            written_ff   <= written_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/byte_level_token_decoder.sv
// ----------------------------------------------------------------------------
// byte_level_token_decoder
// A byte is held in the input register, then in the result register.
// Throughput: one byte per cycle while the result is not stalled; the byte
// decode sits between the two registers, and both advance together.
// Reset (synchronous): clears both stages, the open character and the byte
// count, and sets the output limit to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_level_token_decoder_assert.svh"

module byte_level_token_decoder
   import bltd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // last_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [23:8] byte_count
   output logic             rsp_tlast,   // token_end
   output logic             rsp_tuser,   // emit
   // configuration
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata    // output_limit
);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic                   out_valid_ff;
   bltd_result_type        out_ff;
   logic [COUNT_WIDTH-1:0] limit_ff;
   logic                   advance;
   bltd_result_type        step_result;

   // advance the held byte whenever the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= OUTPUT_LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   bltd_step u_step (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_byte      (in_byte_ff),
      .last_byte    (in_last_ff),
      .output_limit (limit_ff),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.byte_count, out_ff.out_byte};
   assign rsp_tlast  = out_ff.token_end;
   assign rsp_tuser  = out_ff.emit;

   `BLTD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `BLTD_ASSERT(a_drop_zero_byte, clock, reset,
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[7:0] == 8'd0), "dropped item carries data")
   `BLTD_ASSERT(a_emit_counts, clock, reset,
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[23:8] != 16'd0), "emitted byte not counted")
   `BLTD_ASSERT(a_input_holds, clock, reset,
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)), "held byte lost")

endmodule

`default_nettype wire
